// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL of the wheel speed controller.
// Defining ASSERT_OFF turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define WSPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wspc assertion failed");
`define WSPC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("wspc forbidden condition seen");
`else
`define WSPC_ASSERT(lbl, clk, rst_n, prop)
`define WSPC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== design/wspc_pkg.sv =====
// Package of the wheel speed PID controller: payload types, sequencer states,
// register indexes, reset values and arithmetic constants. No dependencies.
package wspc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd4;

    localparam logic [23:0] KP_RESET    = 24'd5898;
    localparam logic [23:0] KI_RESET    = 24'd5931;
    localparam logic [23:0] KD_RESET    = 24'd387;
    localparam logic [23:0] CPR_RESET   = 24'd22118;
    localparam logic [7:0]  LIMIT_RESET = 8'd255;

    // 60 s * 1000 ms, applied before the Q8.16 by Q16.8 alignment shift.
    localparam logic [15:0] RPM_SCALE = 16'd60000;

    localparam logic [31:0] RPM_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] RPM_MIN  = 32'h8000_0000;
    localparam logic [39:0] ESUM_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] ESUM_MIN = 40'h80_0000_0000;
    localparam logic [60:0] TERM_CAP = 61'h1000_0000_0000_0000;

    localparam logic [2:0] SHORT_LAST = 3'd1;
    localparam logic [2:0] LONG_LAST  = 3'd4;
    localparam logic [4:0] DIV_LAST   = 5'd31;

    localparam logic [1:0] TERM_P    = 2'd0;
    localparam logic [1:0] TERM_I    = 2'd1;
    localparam logic [1:0] TERM_D    = 2'd2;
    localparam logic [1:0] TERM_DONE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MNUM,
        S_MDEN,
        S_CHK,
        S_DIV,
        S_SGN,
        S_UPD,
        S_ACC,
        S_MGAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic signed [15:0] target_rpm;
        logic signed [23:0] pulse_count;
        logic        [15:0] elapsed_ms;
    } t_req;

    typedef struct packed {
        logic        [7:0]  drive_forward;
        logic        [7:0]  drive_reverse;
        logic signed [31:0] measured_rpm;
    } t_rsp;

endpackage

// ===== design/wspc_stream_if.sv =====
// Valid/ready channel carrying one request or result per handshake.
// The payload type is supplied by the instantiating level from wspc_pkg.
interface wspc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/wheel_speed_pid_controller_unit.sv =====
// Wheel speed PID controller: encoder rpm by bit-serial division, PID sum by a
// shared 24x8 digit-serial multiplier. Uses wspc_pkg, wspc_stream_if and
// assert_macros.svh.
//
//  channel   direction  payload
//  i_req     in         target_rpm, pulse_count, elapsed_ms
//  o_rsp     out        drive_forward, drive_reverse, measured_rpm
//  i_cfg_*   in         write enable, register index, 24-bit data
//
// Ready falls after each accepted request and rises when the block is idle again, so a new
// request is taken only once the last one has been worked through. The division is skipped
// for zero elapsed time, zero counts per turn or a quotient beyond 32 bits. The work is a
// 32-step restoring divider and 19 digit steps of the shared multiplier. Reset is
// synchronous and restores the gains and the state. A new request is taken while a
// result still waits; the last step holds until the output register is free.
`include "assert_macros.svh"

module wheel_speed_pid_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wspc_stream_if.sink                     i_req,
    wspc_stream_if.source                   o_rsp,
    input  logic                            i_cfg_we,
    input  logic [wspc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wspc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wspc_pkg::t_state r_state, n_state;
    wspc_pkg::t_rsp   r_out, n_out;

    logic [23:0] r_kp, r_ki, r_kd, r_cpr;
    logic [7:0]  r_lim;

    logic [15:0] r_target, n_target;
    logic        r_neg, n_neg;
    logic [15:0] r_ms, n_ms;
    logic [23:0] r_ma, n_ma;
    logic [39:0] r_mb, n_mb;
    logic [23:0] r_mh, n_mh;
    logic [2:0]  r_mcnt, n_mcnt;
    logic        r_msign, n_msign;
    logic [39:0] r_rem, n_rem;
    logic [31:0] r_dvd, n_dvd;
    logic [39:0] r_den, n_den;
    logic        r_ovf, n_ovf;
    logic [4:0]  r_dcnt, n_dcnt;
    logic [31:0] r_rpm, n_rpm;
    logic [32:0] r_err, n_err;
    logic [32:0] r_dlt, n_dlt;
    logic [39:0] r_esum, n_esum;
    logic [31:0] r_prev, n_prev;
    logic [62:0] r_pid, n_pid;
    logic [1:0]  r_term, n_term;
    logic        r_ovld, n_ovld;

    logic [23:0] pulse_mag;
    logic [31:0] mul_prod, mul_sum;
    logic [39:0] mul_full;
    logic [40:0] div_trial, div_diff;
    logic        div_ge;
    logic [32:0] tgt_q, rpm_x, err_x, dlt_x;
    logic [40:0] esum_x;
    logic [39:0] esum_sat;
    logic [32:0] err_mag, dlt_mag;
    logic [39:0] esum_mag;
    logic [63:0] prod_full;
    logic [60:0] prod_cap;
    logic [62:0] term_mag, term_x;
    logic [62:0] pid_mag;
    logic        pid_over;
    logic [7:0]  duty;
    logic        rpm_big;

    assign i_req.ready   = (r_state == wspc_pkg::S_IDLE);
    assign o_rsp.valid   = r_ovld;
    assign o_rsp.payload = r_out;

    always_comb begin
        pulse_mag = i_req.payload.pulse_count[23]
                  ? (24'd0 - i_req.payload.pulse_count)
                  : i_req.payload.pulse_count;

        mul_prod = {8'd0, r_ma} * {24'd0, r_mb[7:0]};
        mul_sum  = {8'd0, r_mh} + mul_prod;
        mul_full = {mul_sum, r_mb[39:32]};

        div_trial = {r_rem, r_dvd[31]};
        div_diff  = div_trial - {1'b0, r_den};
        div_ge    = (div_trial >= {1'b0, r_den});

        rpm_big = r_ovf | r_dvd[31];

        tgt_q  = {{9{r_target[15]}}, r_target, 8'd0};
        rpm_x  = {r_rpm[31], r_rpm};
        err_x  = tgt_q - rpm_x;
        dlt_x  = rpm_x - {r_prev[31], r_prev};
        esum_x = {r_esum[39], r_esum} + {{8{err_x[32]}}, err_x};
        if (esum_x[40] != esum_x[39]) begin
            esum_sat = esum_x[40] ? wspc_pkg::ESUM_MIN : wspc_pkg::ESUM_MAX;
        end else begin
            esum_sat = esum_x[39:0];
        end

        err_mag  = r_err[32] ? (33'd0 - r_err) : r_err;
        dlt_mag  = r_dlt[32] ? (33'd0 - r_dlt) : r_dlt;
        esum_mag = r_esum[39] ? (40'd0 - r_esum) : r_esum;

        prod_full = {r_mh, r_mb};
        prod_cap  = (prod_full > {3'd0, wspc_pkg::TERM_CAP}) ? wspc_pkg::TERM_CAP
                                                            : prod_full[60:0];
        term_mag  = {2'd0, prod_cap};
        term_x    = r_msign ? (63'd0 - term_mag) : term_mag;

        pid_mag  = r_pid[62] ? (63'd0 - r_pid) : r_pid;
        pid_over = (pid_mag > {31'd0, r_lim, 24'd0});
        duty     = pid_over ? r_lim : pid_mag[31:24];

        n_state  = r_state;
        n_out    = r_out;
        n_target = r_target;
        n_neg    = r_neg;
        n_ms     = r_ms;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_mh     = r_mh;
        n_mcnt   = r_mcnt;
        n_msign  = r_msign;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_den    = r_den;
        n_ovf    = r_ovf;
        n_dcnt   = r_dcnt;
        n_rpm    = r_rpm;
        n_err    = r_err;
        n_dlt    = r_dlt;
        n_esum   = r_esum;
        n_prev   = r_prev;
        n_pid    = r_pid;
        n_term   = r_term;
        n_ovld   = r_ovld;

        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            wspc_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_target = i_req.payload.target_rpm;
                    n_neg    = i_req.payload.pulse_count[23];
                    n_ms     = i_req.payload.elapsed_ms;
                    n_ma     = pulse_mag;
                    n_mb     = {24'd0, wspc_pkg::RPM_SCALE};
                    n_mh     = 24'd0;
                    n_mcnt   = wspc_pkg::SHORT_LAST;
                    n_state  = wspc_pkg::S_MNUM;
                end
            end
            wspc_pkg::S_MNUM: begin
                n_mh   = mul_sum[31:8];
                n_mb   = {mul_sum[7:0], r_mb[39:8]};
                n_mcnt = r_mcnt - 3'd1;
                if (r_mcnt == 3'd0) begin
                    // Dividend is the product shifted up by 16 bits.
                    n_rem   = {17'd0, mul_full[38:16]};
                    n_dvd   = {mul_full[15:0], 16'd0};
                    n_ma    = r_cpr;
                    n_mb    = {24'd0, r_ms};
                    n_mh    = 24'd0;
                    n_mcnt  = wspc_pkg::SHORT_LAST;
                    n_state = wspc_pkg::S_MDEN;
                end
            end
            wspc_pkg::S_MDEN: begin
                n_mh   = mul_sum[31:8];
                n_mb   = {mul_sum[7:0], r_mb[39:8]};
                n_mcnt = r_mcnt - 3'd1;
                if (r_mcnt == 3'd0) begin
                    n_den   = mul_full;
                    n_state = wspc_pkg::S_CHK;
                end
            end
            wspc_pkg::S_CHK: begin
                n_dcnt = wspc_pkg::DIV_LAST;
                n_ovf  = 1'b0;
                if (r_den == 40'd0) begin
                    n_dvd   = 32'd0;
                    n_state = wspc_pkg::S_SGN;
                end else if (r_rem >= r_den) begin
                    // Quotient would need more than 32 bits.
                    n_ovf   = 1'b1;
                    n_state = wspc_pkg::S_SGN;
                end else begin
                    n_state = wspc_pkg::S_DIV;
                end
            end
            wspc_pkg::S_DIV: begin
                n_rem  = div_ge ? div_diff[39:0] : div_trial[39:0];
                n_dvd  = {r_dvd[30:0], div_ge};
                n_dcnt = r_dcnt - 5'd1;
                if (r_dcnt == 5'd0) begin
                    n_state = wspc_pkg::S_SGN;
                end
            end
            wspc_pkg::S_SGN: begin
                if (r_neg) begin
                    n_rpm = rpm_big ? wspc_pkg::RPM_MIN : (32'd0 - r_dvd);
                end else begin
                    n_rpm = rpm_big ? wspc_pkg::RPM_MAX : r_dvd;
                end
                n_state = wspc_pkg::S_UPD;
            end
            wspc_pkg::S_UPD: begin
                n_err   = err_x;
                n_dlt   = dlt_x;
                n_esum  = esum_sat;
                n_pid   = 63'd0;
                n_term  = wspc_pkg::TERM_P;
                n_state = wspc_pkg::S_ACC;
            end
            wspc_pkg::S_ACC: begin
                if (r_term != wspc_pkg::TERM_P) begin
                    n_pid = r_pid + term_x;
                end
                n_mh   = 24'd0;
                n_mcnt = wspc_pkg::LONG_LAST;
                n_term = r_term + 2'd1;
                case (r_term)
                    wspc_pkg::TERM_P: begin
                        n_ma    = r_kp;
                        n_mb    = {7'd0, err_mag};
                        n_msign = r_err[32];
                        n_state = wspc_pkg::S_MGAIN;
                    end
                    wspc_pkg::TERM_I: begin
                        n_ma    = r_ki;
                        n_mb    = esum_mag;
                        n_msign = r_esum[39];
                        n_state = wspc_pkg::S_MGAIN;
                    end
                    wspc_pkg::TERM_D: begin
                        n_ma    = r_kd;
                        n_mb    = {7'd0, dlt_mag};
                        n_msign = r_dlt[32];
                        n_state = wspc_pkg::S_MGAIN;
                    end
                    default: begin
                        n_term  = r_term;
                        n_state = wspc_pkg::S_FIN;
                    end
                endcase
            end
            wspc_pkg::S_MGAIN: begin
                n_mh   = mul_sum[31:8];
                n_mb   = {mul_sum[7:0], r_mb[39:8]};
                n_mcnt = r_mcnt - 3'd1;
                if (r_mcnt == 3'd0) begin
                    n_state = wspc_pkg::S_ACC;
                end
            end
            wspc_pkg::S_FIN: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_out.drive_forward = 8'd0;
                    n_out.drive_reverse = 8'd0;
                    n_out.measured_rpm  = r_rpm;
                    if (r_target == 16'd0) begin
                        n_esum = 40'd0;
                    end else if (r_pid[62]) begin
                        n_out.drive_reverse = duty;
                    end else begin
                        n_out.drive_forward = duty;
                    end
                    n_prev  = r_rpm;
                    n_ovld  = 1'b1;
                    n_state = wspc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wspc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wspc_pkg::S_IDLE;
            r_ovld  <= 1'b0;
            r_esum  <= 40'd0;
            r_prev  <= 32'd0;
            r_mcnt  <= 3'd0;
            r_dcnt  <= 5'd0;
            r_term  <= wspc_pkg::TERM_P;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_esum  <= n_esum;
            r_prev  <= n_prev;
            r_mcnt  <= n_mcnt;
            r_dcnt  <= n_dcnt;
            r_term  <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_target <= n_target;
        r_neg    <= n_neg;
        r_ms     <= n_ms;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_mh     <= n_mh;
        r_msign  <= n_msign;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_den    <= n_den;
        r_ovf    <= n_ovf;
        r_rpm    <= n_rpm;
        r_err    <= n_err;
        r_dlt    <= n_dlt;
        r_pid    <= n_pid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= wspc_pkg::KP_RESET;
            r_ki  <= wspc_pkg::KI_RESET;
            r_kd  <= wspc_pkg::KD_RESET;
            r_cpr <= wspc_pkg::CPR_RESET;
            r_lim <= wspc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wspc_pkg::CFG_KP:    r_kp  <= i_cfg_data;
                wspc_pkg::CFG_KI:    r_ki  <= i_cfg_data;
                wspc_pkg::CFG_KD:    r_kd  <= i_cfg_data;
                wspc_pkg::CFG_CPR:   r_cpr <= i_cfg_data;
                wspc_pkg::CFG_LIMIT: r_lim <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The partial remainder never reaches the divisor, and the divisor is never zero.
    `WSPC_ASSERT(a_div_rem, i_clk, i_rst_n, (r_state == wspc_pkg::S_DIV) |-> (r_rem < r_den))
    `WSPC_ASSERT(a_div_den, i_clk, i_rst_n, (r_state == wspc_pkg::S_DIV) |-> (r_den != 40'd0))
    `WSPC_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_ovld) |-> ($past(r_state) == wspc_pkg::S_FIN))
    `WSPC_ASSERT_NEVER(a_drv_both, i_clk, i_rst_n, r_ovld && (r_out.drive_forward != 8'd0) && (r_out.drive_reverse != 8'd0))

endmodule

// ===== tb/wspc_drive_checker.sv =====
// Checker for the wheel speed PID controller: follows the register writes,
// predicts each drive result and compares it with what the block sends back.
// Depends on wspc_pkg for the payload types and the register indexes.
module wspc_drive_checker
    import wspc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_req                  i_req_payload,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  t_rsp                  i_rsp_payload,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_drives_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ESUM_HI    = 64'sd549755813887;
    localparam longint ESUM_LO    = -64'sd549755813888;
    localparam logic [63:0] PRODUCT_CAP = 64'd1 << 60;

    logic [23:0] kp_q;
    logic [23:0] ki_q;
    logic [23:0] kd_q;
    logic [23:0] cpr_q;
    logic [7:0]  limit_q;
    longint      error_sum;
    longint      last_speed;
    t_rsp        expected_drives[$];
    t_rsp        want;
    int          mismatch_count = 0;
    int          owed = 0;

    assign o_fail_count  = mismatch_count;
    assign o_drives_owed = owed;

    task automatic report_mismatch(input string what);
        $display("[%0t] drive check: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint scaled_term(input logic [23:0] gain, input longint v);
        logic [63:0] p;
        p = 64'(gain) * magnitude(v);
        if (p > PRODUCT_CAP) begin
            p = PRODUCT_CAP;
        end
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint measure_speed(input longint pulses, input logic [15:0] ms);
        logic [63:0] den;
        logic [63:0] q;
        den = 64'(cpr_q) * 64'(ms);
        if (den == 0) begin
            return 0;
        end
        q = (magnitude(pulses) * 64'd60000 * 64'd65536) / den;
        if (pulses < 0) begin
            if (q > 64'd2147483648) begin
                q = 64'd2147483648;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647) begin
            q = 64'd2147483647;
        end
        return longint'(q);
    endfunction

    // Advances the integral and the previous speed as the block does.
    function automatic t_rsp predict_drive(input t_req tick);
        longint setp;
        longint pulses;
        longint speed;
        longint err;
        longint total;
        longint lim;
        longint duty;
        t_rsp   r;
        setp   = {{48{tick.target_rpm[15]}}, tick.target_rpm};
        pulses = {{40{tick.pulse_count[23]}}, tick.pulse_count};
        speed  = measure_speed(pulses, tick.elapsed_ms);
        err    = setp * 256 - speed;
        error_sum = error_sum + err;
        if (error_sum > ESUM_HI) begin
            error_sum = ESUM_HI;
        end
        if (error_sum < ESUM_LO) begin
            error_sum = ESUM_LO;
        end
        total = scaled_term(kp_q, err) + scaled_term(ki_q, error_sum)
              + scaled_term(kd_q, speed - last_speed);
        lim = limit_q;
        lim = lim <<< 24;
        if (total > lim) begin
            total = lim;
        end
        if (total < -lim) begin
            total = -lim;
        end
        r = '0;
        if (setp == 0) begin
            error_sum = 0;
        end else if (total >= 0) begin
            duty = total >>> 24;
            r.drive_forward = duty[7:0];
        end else begin
            duty = (-total) >>> 24;
            r.drive_reverse = duty[7:0];
        end
        last_speed = speed;
        r.measured_rpm = speed[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp_q       = KP_RESET;
            ki_q       = KI_RESET;
            kd_q       = KD_RESET;
            cpr_q      = CPR_RESET;
            limit_q    = LIMIT_RESET;
            error_sum  = 0;
            last_speed = 0;
            expected_drives.delete();
            owed = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:    kp_q    = i_cfg_data;
                    CFG_KI:    ki_q    = i_cfg_data;
                    CFG_KD:    kd_q    = i_cfg_data;
                    CFG_CPR:   cpr_q   = i_cfg_data;
                    CFG_LIMIT: limit_q = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch($sformatf("result with no request outstanding: %p",
                                              i_rsp_payload));
                end else begin
                    want = expected_drives.pop_front();
                    if (i_rsp_payload.drive_forward !== want.drive_forward) begin
                        report_mismatch($sformatf("drive_forward %0d, expected %0d",
                                                  i_rsp_payload.drive_forward,
                                                  want.drive_forward));
                    end
                    if (i_rsp_payload.drive_reverse !== want.drive_reverse) begin
                        report_mismatch($sformatf("drive_reverse %0d, expected %0d",
                                                  i_rsp_payload.drive_reverse,
                                                  want.drive_reverse));
                    end
                    if (i_rsp_payload.measured_rpm !== want.measured_rpm) begin
                        report_mismatch($sformatf("measured_rpm %0d, expected %0d",
                                                  $signed(i_rsp_payload.measured_rpm),
                                                  $signed(want.measured_rpm)));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_drives.push_back(predict_drive(i_req_payload));
            end
            owed = expected_drives.size();
        end
    end

endmodule

// ===== tb/wheel_speed_pid_controller_unit_tb.sv =====
// Top of the testbench for the wheel speed PID controller: clock, reset,
// request and register stimulus, result pacing and the verdict.
// Depends on wspc_pkg, wspc_stream_if, the block itself and wspc_drive_checker.
module wheel_speed_pid_controller_unit_tb;
    import wspc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 70;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    drives_owed;
    bit                    back_to_back = 1'b0;

    wspc_stream_if #(.t_payload(t_req)) req_ch ();
    wspc_stream_if #(.t_payload(t_rsp)) rsp_ch ();

    wheel_speed_pid_controller_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    wspc_drive_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req_payload (req_ch.payload),
        .i_rsp_valid   (rsp_ch.valid),
        .i_rsp_ready   (rsp_ch.ready),
        .i_rsp_payload (rsp_ch.payload),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_drives_owed (drives_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_req tick_of(input logic [15:0] target, input logic [23:0] pulses,
                                     input logic [15:0] ms);
        t_req t;
        t.target_rpm  = target;
        t.pulse_count = pulses;
        t.elapsed_ms  = ms;
        return t;
    endfunction

    function automatic t_req random_tick();
        t_req        t;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        t.target_rpm  = 16'(int'($urandom_range(0, 6000)) - 3000);
        t.pulse_count = 24'(int'($urandom_range(0, 10000)) - 5000);
        t.elapsed_ms  = 16'($urandom_range(1, 200));
        if (pick < 3) begin
            t.target_rpm  = 16'($urandom);
            t.pulse_count = 24'($urandom);
            t.elapsed_ms  = 16'($urandom);
        end else if (pick < 5) begin
            t.target_rpm = '0;
        end else if (pick == 5) begin
            t.elapsed_ms = '0;
        end
        return t;
    endfunction

    // Drives the integral towards one end of its range.
    function automatic t_req windup_tick(input bit upward);
        t_req t;
        if (upward) begin
            t.target_rpm  = 16'($urandom_range(20000, 32767));
            t.pulse_count = 24'(-int'($urandom_range(4000000, 8388608)));
        end else begin
            t.target_rpm  = 16'(-int'($urandom_range(20000, 32768)));
            t.pulse_count = 24'($urandom_range(4000000, 8388607));
        end
        t.elapsed_ms = 16'($urandom_range(1, 3));
        return t;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(input t_req tick);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.payload = tick;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (drives_owed != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [23:0] kp, input logic [23:0] ki,
                             input logic [23:0] kd, input logic [23:0] cpr,
                             input logic [7:0] limit);
        wait_drained();
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_CPR, cpr);
        write_reg(CFG_LIMIT, {16'd0, limit});
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                back_to_back = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_drained();
            end
            send_tick(random_tick());
        end
    endtask

    task automatic run_windup(input bit upward, input int count);
        repeat (count) send_tick(windup_tick(upward));
    endtask

    initial begin : result_pacing
        int unsigned hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = (hold == 0);
            if (hold != 0) begin
                hold--;
            end
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                hold = back_to_back ? 0 : $urandom_range(0, 4);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_tick(tick_of(16'd0, 24'd0, 16'd0));
        send_tick(tick_of(16'd32767, 24'd8388607, 16'd1));
        send_tick(tick_of(-16'sd32768, -24'sd8388608, 16'd1));
        send_tick(tick_of(16'd100, 24'd9, 16'd100));
        send_tick(tick_of(16'd100, 24'd20, 16'd100));
        send_tick(tick_of(-16'sd100, -24'sd15, 16'd100));
        send_tick(tick_of(16'd500, 24'd1000, 16'd0));
        send_tick(tick_of(16'd0, 24'd500, 16'd50));
        send_tick(tick_of(16'd1, 24'd1, 16'd65535));
        send_tick(tick_of(-16'sd1, -24'sd1, 16'd65535));
        send_tick(tick_of(16'd32767, 24'd0, 16'd65535));
        send_tick(tick_of(-16'sd32768, 24'd0, 16'd1));
        send_tick(tick_of(16'd200, -24'sd300, 16'd20));
        send_tick(tick_of(16'd0, -24'sd8388608, 16'd65535));
        send_tick(tick_of(-16'sd32768, 24'd8388607, 16'd65535));

        wait_drained();
        write_reg(CFG_LIMIT, 24'd0);
        send_tick(tick_of(16'd100, 24'd9, 16'd100));
        send_tick(tick_of(-16'sd100, -24'sd9, 16'd100));
        send_tick(tick_of(16'd32767, -24'sd8388608, 16'd1));

        wait_drained();
        write_reg(CFG_CPR, 24'd0);
        send_tick(tick_of(16'd100, 24'd50, 16'd100));
        send_tick(tick_of(-16'sd100, -24'sd50, 16'd10));

        configure(KP_RESET, KI_RESET, KD_RESET, CPR_RESET, LIMIT_RESET);
        run_random(300);

        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 8'd255);
        run_windup(1'b1, 270);
        send_tick(tick_of(16'd0, 24'd0, 16'd1));
        run_windup(1'b0, 270);
        run_random(60);

        configure(24'd0, 24'd0, 24'd0, 24'hFFFFFF, 8'd128);
        run_random(150);

        configure(24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom_range(1, 16777215)), 8'($urandom));
        run_random(150);

        configure(24'($urandom_range(0, 20000)), 24'($urandom_range(0, 20000)),
                  24'($urandom_range(0, 20000)), 24'($urandom_range(10000, 40000)),
                  8'($urandom_range(1, 255)));
        run_random(150);

        configure(KP_RESET, KI_RESET, KD_RESET, CPR_RESET, 8'd255);
        run_random(150);

        req_ch.valid = 1'b0;
        while (drives_owed != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && drives_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
